/* rtl/core/csrsmv_pkg.sv */
package csrsmv_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = 40;
    localparam int ROWI_W  = 16;
    localparam int VLEN_W  = 11;
    localparam int RCNT_W  = 17;
    localparam int CFGD_W  = 17;
    localparam int SIN_W   = 32;
    localparam int MOUT_W  = 64;

    localparam logic [VLEN_W-1:0] VLEN_RST = VLEN_W'(1024);
    localparam logic [RCNT_W-1:0] RCNT_RST = RCNT_W'(1);

    typedef enum logic [0:0] {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_ROW_COUNT     = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_ENTRY = 2'd1,
        MODE_EMPTY = 2'd2
    } t_mode;

    typedef struct packed {
        logic              entry;
        logic              emit;
        logic              col_ok;
        logic [VAL_W-1:0]  value;
    } t_rd_stage;

    typedef struct packed {
        logic               entry;
        logic               emit;
        logic               col_ok;
        logic [PROD_W-1:0]  prod;
    } t_mul_stage;

endpackage

/* rtl/core/csr_sparse_matvec_top.sv */
// Channel  Dir  Handshake                          Payload
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready  tdata: element_index, entry_value
//                                                  tuser: mode, tlast: last_in_row
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready  tdata: row_index, row_sum
//                                                  tuser: saturated, bad_column
//                                                  tlast: last_row
// cfg      in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// One word per cycle unless stalled. Vector read, multiply and saturating accumulate
// form a three-stage pipe; a row sum is registered as its closing word leaves it.
// The accumulate loop is a single 41-bit add and clamp per cycle.
// Synchronous active-low reset clears control state; the vector store is not cleared.
// Input stalls only when a closing word reaches the accumulator while the
// output register is still held by the sink.
module csr_sparse_matvec_top #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int MAX_ROWS     = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cfg
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [csrsmv_pkg::CFGD_W-1:0] i_cfg_data,
    // slave stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [9:0] element_index, [25:10] entry_value, [31:26] zero
    input  logic [csrsmv_pkg::SIN_W-1:0]  i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                    i_s_axis_tuser,
    input  logic                          i_s_axis_tlast,
    // master stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] row_index, [55:16] row_sum, [63:56] zero
    output logic [csrsmv_pkg::MOUT_W-1:0] o_m_axis_tdata,
    // [0] saturated, [1] bad_column
    output logic [1:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);
    import csrsmv_pkg::*;

    localparam int AW   = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int VW0  = $clog2(VECTOR_DEPTH + 1);
    localparam int VW   = (VW0 > VLEN_W) ? VW0 : VLEN_W;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW0  = $clog2(MAX_ROWS + 1);
    localparam int CW   = (CW0 > RCNT_W) ? CW0 : RCNT_W;

    logic [VAL_W-1:0]  r_mem [VECTOR_DEPTH];
    logic [VAL_W-1:0]  r_rd_data;

    logic [VLEN_W-1:0] r_vlen;
    logic [RCNT_W-1:0] r_rcnt;

    logic              r_v1, n_v1;
    t_rd_stage         r_s1, n_s1;
    logic              r_v2;
    t_mul_stage        r_s2;

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic              r_sat, n_sat;
    logic              r_err, n_err;
    logic [RW-1:0]     r_row, n_row;

    logic              r_out_valid;
    logic [ROWI_W-1:0] r_out_row;
    logic [ACC_W-1:0]  r_out_sum;
    logic              r_out_sat;
    logic              r_out_err;
    logic              r_out_last;

    logic              hold;
    logic              advance;
    logic              accept;
    logic              emit_now;

    logic [IDX_W-1:0]  in_idx;
    logic [VAL_W-1:0]  in_val;
    logic [VW-1:0]     idx_w;
    logic              idx_in_depth;
    logic [AW-1:0]     addr;
    logic [AW+IDX_W-1:0] idx_ext;

    logic [CW-1:0]     rc_w;
    logic [CW-1:0]     rows_m1;
    logic              is_last;
    logic [RW+ROWI_W-1:0] row_ext;

    logic [ACC_W:0]    sum;
    logic              ovf;
    logic [ACC_W-1:0]  acc_add;

    // cfg
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_RST;
            r_rcnt <= RCNT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VECTOR_LENGTH: r_vlen <= i_cfg_data[VLEN_W-1:0];
                CFG_ROW_COUNT:     r_rcnt <= i_cfg_data[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign hold            = r_v2 && r_s2.emit && r_out_valid && !i_m_axis_tready;
    assign advance         = !hold;
    assign o_s_axis_tready = advance;
    assign accept          = i_s_axis_tvalid && advance;

    // stage 0: decode, vector store access
    assign in_idx       = i_s_axis_tdata[IDX_W-1:0];
    assign in_val       = i_s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
    assign idx_w        = VW'(in_idx);
    assign idx_in_depth = idx_w < VW'(VECTOR_DEPTH);
    assign idx_ext      = {{AW{1'b0}}, in_idx};
    assign addr         = idx_ext[AW-1:0];

    always_comb begin
        n_v1        = 1'b0;
        n_s1.entry  = 1'b0;
        n_s1.emit   = 1'b0;
        n_s1.col_ok = idx_in_depth && (idx_w < VW'(r_vlen));
        n_s1.value  = in_val;
        unique case (i_s_axis_tuser)
            MODE_ENTRY: begin
                n_v1       = accept;
                n_s1.entry = 1'b1;
                n_s1.emit  = i_s_axis_tlast;
            end
            MODE_EMPTY: begin
                n_v1      = accept;
                n_s1.emit = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_s_axis_tuser == MODE_LOAD) && idx_in_depth) begin
            r_mem[addr] <= in_val;
        end
        if (advance) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // stage 1 and 2 pipe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (advance) begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1         <= n_s1;
            r_s2.entry   <= r_s1.entry;
            r_s2.emit    <= r_s1.emit;
            r_s2.col_ok  <= r_s1.col_ok;
            r_s2.prod    <= PROD_W'($signed(r_s1.value) * $signed(r_rd_data));
        end
    end

    // stage 2: saturating accumulate, row close
    assign sum     = {r_acc[ACC_W-1], r_acc}
                   + {{(ACC_W+1-PROD_W){r_s2.prod[PROD_W-1]}}, r_s2.prod};
    assign ovf     = sum[ACC_W] != sum[ACC_W-1];
    assign acc_add = ovf ? (sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}})
                         : sum[ACC_W-1:0];

    assign rc_w    = CW'(r_rcnt);
    always_comb begin
        priority if (rc_w == '0) begin
            rows_m1 = '0;
        end else if (rc_w > CW'(MAX_ROWS)) begin
            rows_m1 = CW'(MAX_ROWS - 1);
        end else begin
            rows_m1 = rc_w - CW'(1);
        end
    end
    assign is_last = CW'(r_row) >= rows_m1;
    assign row_ext = {{ROWI_W{1'b0}}, r_row};

    always_comb begin
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_err    = r_err;
        emit_now = 1'b0;
        if (advance && r_v2) begin
            if (r_s2.entry) begin
                if (r_s2.col_ok) begin
                    n_acc = acc_add;
                    n_sat = r_sat || ovf;
                end else begin
                    n_err = 1'b1;
                end
            end
            emit_now = r_s2.emit;
        end
    end

    always_comb begin
        n_row = r_row;
        if (emit_now) begin
            n_row = is_last ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
            r_err <= 1'b0;
            r_row <= '0;
        end else begin
            r_row <= n_row;
            if (emit_now) begin
                r_acc <= '0;
                r_sat <= 1'b0;
                r_err <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_sat <= n_sat;
                r_err <= n_err;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_now) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_out_row  <= row_ext[ROWI_W-1:0];
            r_out_sum  <= n_acc;
            r_out_sat  <= n_sat;
            r_out_err  <= n_err;
            r_out_last <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(MOUT_W-ROWI_W-ACC_W){1'b0}}, r_out_sum, r_out_row};
    assign o_m_axis_tuser  = {r_out_err, r_out_sat};
    assign o_m_axis_tlast  = r_out_last;

endmodule
